@@ rtl/gray_minpool_binarize_macros.svh @@
// ----------------------------------------------------------------------------
// gray_minpool_binarize_macros
// Assertion macros used by the gray min-pool binarizer RTL.
// ----------------------------------------------------------------------------
`ifndef GRAY_MINPOOL_BINARIZE_MACROS_SVH
`define GRAY_MINPOOL_BINARIZE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define GMB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define GMB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gmb_pkg.sv @@
// ----------------------------------------------------------------------------
// gmb_pkg
// Types and constants for the gray min-pool binarizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmb_pkg;

    // Window limits and derived sizes
    localparam int MAX_ROW_PIXELS = 64;
    localparam int MAX_FRAME_ROWS = 64;
    localparam int LINE_DEPTH     = MAX_ROW_PIXELS / 2;
    localparam int SLOT_W         = $clog2(LINE_DEPTH);
    localparam int COUNT_W        = 6;
    localparam int SIZE_W         = 7;
    localparam int PIX_W          = 16;
    localparam int GRAY_W         = 8;
    localparam int LUMA_W         = 24;

    localparam logic [SIZE_W-1:0] MAX_ROW_SIZE   = SIZE_W'(MAX_ROW_PIXELS);
    localparam logic [SIZE_W-1:0] MAX_FRAME_SIZE = SIZE_W'(MAX_FRAME_ROWS);
    localparam logic [SIZE_W-1:0] MIN_SIZE       = SIZE_W'(2);

    // Q0.16 luma weights and the 128.0 offset
    localparam logic [LUMA_W-1:0] W_RED      = LUMA_W'(13933);
    localparam logic [LUMA_W-1:0] W_GREEN    = LUMA_W'(46872);
    localparam logic [LUMA_W-1:0] W_BLUE     = LUMA_W'(4732);
    localparam logic [LUMA_W-1:0] OFFSET_Q16 = LUMA_W'(128 << 16);

    // Register reset values
    localparam logic [SIZE_W-1:0]        ROW_PIXELS_RST     = SIZE_W'(56);
    localparam logic [SIZE_W-1:0]        FRAME_ROWS_RST     = SIZE_W'(56);
    localparam logic signed [GRAY_W-1:0] KEEP_THRESHOLD_RST = 8'sd50;
    localparam logic signed [GRAY_W-1:0] FILL_VALUE_RST     = -8'sd120;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROW_PIXELS     = 2'd0,
        CFG_FRAME_ROWS     = 2'd1,
        CFG_KEEP_THRESHOLD = 2'd2,
        CFG_FILL_VALUE     = 2'd3
    } cfg_index_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [SIZE_W-1:0]        row_pixels;
        logic [SIZE_W-1:0]        frame_rows;
        logic signed [GRAY_W-1:0] keep_threshold;
        logic signed [GRAY_W-1:0] fill_value;
    } cfg_t;

    // One gray pixel handed from the luma stage to the pooling stage
    typedef struct packed {
        logic                     valid;
        logic                     frame_start;
        logic signed [GRAY_W-1:0] gray;
    } gray_item_t;

endpackage

@@ rtl/gmb_cfg.sv @@
// ----------------------------------------------------------------------------
// gmb_cfg
// Configuration register file: window size, threshold and fill value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmb_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  gmb_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data,
    output gmb_pkg::cfg_t       cfg
);
    import gmb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Accept a write every cycle
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write transaction
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROW_PIXELS:     cfg_next.row_pixels     = cfg_data[SIZE_W-1:0];
                CFG_FRAME_ROWS:     cfg_next.frame_rows     = cfg_data[SIZE_W-1:0];
                CFG_KEEP_THRESHOLD: cfg_next.keep_threshold = $signed(cfg_data);
                CFG_FILL_VALUE:     cfg_next.fill_value     = $signed(cfg_data);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_pixels     <= ROW_PIXELS_RST;
            cfg_reg.frame_rows     <= FRAME_ROWS_RST;
            cfg_reg.keep_threshold <= KEEP_THRESHOLD_RST;
            cfg_reg.fill_value     <= FILL_VALUE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/gmb_luma.sv @@
// ----------------------------------------------------------------------------
// gmb_luma
// Input register and RGB565 to signed luma conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmb_luma (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gmb_pkg::PIX_W-1:0]     s_pixel_rgb565,
    input  logic                          s_frame_start,
    output gmb_pkg::gray_item_t           item,
    input  logic                          item_take
);
    import gmb_pkg::*;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [PIX_W-1:0] pixel_reg;
    logic             frame_start_reg;

    logic [7:0]        red8;
    logic [7:0]        green8;
    logic [7:0]        blue8;
    logic [LUMA_W-1:0] luma_sum;
    logic [LUMA_W-1:0] pos_diff;
    logic [LUMA_W-1:0] neg_diff;
    logic [GRAY_W-1:0] gray_bits;

    // Take a new transaction when empty or when the pool stage drains this one
    assign s_ready = !in_valid_reg || item_take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (item_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pixel_reg       <= s_pixel_rgb565;
            frame_start_reg <= s_frame_start;
        end
    end

    // Widen channels to 8 bits and weight them in Q0.16
    always_comb begin
        red8     = {pixel_reg[15:11], 3'b000};
        green8   = {pixel_reg[10:5], 2'b00};
        blue8    = {pixel_reg[4:0], 3'b000};
        luma_sum = LUMA_W'(red8) * W_RED + LUMA_W'(green8) * W_GREEN
                 + LUMA_W'(blue8) * W_BLUE;
        pos_diff = luma_sum - OFFSET_Q16;
        neg_diff = OFFSET_Q16 - luma_sum;
        // Subtract 128 and truncate toward zero
        if (luma_sum >= OFFSET_Q16) begin
            gray_bits = pos_diff[LUMA_W-1:16];
        end else begin
            gray_bits = 8'd0 - neg_diff[LUMA_W-1:16];
        end
    end

    assign item.valid       = in_valid_reg;
    assign item.frame_start = frame_start_reg;
    assign item.gray        = $signed(gray_bits);

endmodule

@@ rtl/gmb_pool.sv @@
// ----------------------------------------------------------------------------
// gmb_pool
// 2x2 minimum pooling with a half-row line store, threshold and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmb_pool (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  gmb_pkg::cfg_t                    cfg,
    input  gmb_pkg::gray_item_t              item,
    output logic                             item_take,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [gmb_pkg::GRAY_W-1:0] m_pooled_value,
    output logic                             m_row_end,
    output logic                             m_frame_end
);
    import gmb_pkg::*;

    // Clamp to the legal range, then force even
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max_v);
        logic [SIZE_W-1:0] c;
        begin
            c = v;
            if (c < MIN_SIZE) c = MIN_SIZE;
            if (c > max_v) c = max_v;
            return {c[SIZE_W-1:1], 1'b0};
        end
    endfunction

    logic [COUNT_W-1:0]       col_reg;
    logic [COUNT_W-1:0]       col_next;
    logic [COUNT_W-1:0]       row_reg;
    logic [COUNT_W-1:0]       row_next;
    logic signed [GRAY_W-1:0] pair_reg;
    logic signed [GRAY_W-1:0] pair_next;
    logic signed [GRAY_W-1:0] line_reg [LINE_DEPTH];

    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [GRAY_W-1:0] m_value_reg;
    logic                     m_row_end_reg;
    logic                     m_frame_end_reg;

    logic [SIZE_W-1:0]        width;
    logic [SIZE_W-1:0]        height;
    logic [COUNT_W-1:0]       col_cur;
    logic [COUNT_W-1:0]       row_cur;
    logic [SLOT_W-1:0]        slot;
    logic signed [GRAY_W-1:0] pair_min;
    logic signed [GRAY_W-1:0] block_min;
    logic signed [GRAY_W-1:0] result_value;
    logic                     produces;
    logic                     line_write;
    logic                     last_col;
    logic                     last_row;
    logic                     out_free;
    logic [SIZE_W-1:0]        col_inc;
    logic [SIZE_W-1:0]        row_inc;

    assign width  = eff_size(cfg.row_pixels, MAX_ROW_SIZE);
    assign height = eff_size(cfg.frame_rows, MAX_FRAME_SIZE);

    // Position of this pixel; frame start restarts both counters
    assign col_cur = item.frame_start ? '0 : col_reg;
    assign row_cur = item.frame_start ? '0 : row_reg;
    assign slot    = col_cur[SLOT_W:1];

    // Pair and block minima
    assign pair_min  = (item.gray < pair_reg) ? item.gray : pair_reg;
    assign block_min = (line_reg[slot] < pair_min) ? line_reg[slot] : pair_min;
    assign result_value = (block_min > cfg.keep_threshold) ? block_min : cfg.fill_value;

    assign produces   = col_cur[0] && row_cur[0];
    assign line_write = item_take && col_cur[0] && !row_cur[0];
    assign last_col   = ({1'b0, col_cur} == (width - SIZE_W'(1)));
    assign last_row   = ({1'b0, row_cur} == (height - SIZE_W'(1)));

    // Drain the pixel unless its result would overwrite a waiting one
    assign out_free  = !m_valid_reg || m_ready;
    assign item_take = item.valid && (!produces || out_free);

    // Advance counters and the pair register
    always_comb begin
        col_inc   = {1'b0, col_cur} + SIZE_W'(1);
        row_inc   = {1'b0, row_cur} + SIZE_W'(1);
        col_next  = col_reg;
        row_next  = row_reg;
        pair_next = pair_reg;
        if (item_take) begin
            if (!col_cur[0]) begin
                pair_next = item.gray;
            end
            if (col_inc >= width) begin
                col_next = '0;
                row_next = (row_inc >= height) ? '0 : row_inc[COUNT_W-1:0];
            end else begin
                col_next = col_inc[COUNT_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pair_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pair_reg <= pair_next;
        end
    end

    // Line store holds pair minima of the even row; no reset
    always_ff @(posedge aclk) begin
        if (line_write) begin
            line_reg[slot] <= pair_min;
        end
    end

    // Result register: load on a producing pixel, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (item_take && produces) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && produces) begin
            m_value_reg     <= result_value;
            m_row_end_reg   <= last_col;
            m_frame_end_reg <= last_col && last_row;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pooled_value = m_value_reg;
    assign m_row_end      = m_row_end_reg;
    assign m_frame_end    = m_frame_end_reg;

endmodule

@@ rtl/gray_minpool_binarize.sv @@
// ----------------------------------------------------------------------------
// gray_minpool_binarize
// RGB565 pixels to signed luma, 2x2 minimum pooling and threshold.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_      | in        | pixel_rgb565[15:0], frame_start
//  m_      | out       | pooled_value[7:0] signed, row_end, frame_end
//  cfg_    | in        | cfg_index[1:0], cfg_data[7:0]
//
//  One pixel per clock sustained while the m_ channel does not stall; an
//  accepted pixel passes the input register, then the result register,
//  before its result is valid and can be taken.
//  The pooling stage is a single pass: counters, pair register and a
//  32-entry line store of flops are updated in the cycle a pixel drains.
//  Synchronous active-low reset clears counters, pair minimum and valids;
//  the line store is not cleared. A stalled m_ channel holds one result and
//  one more pixel; pixels that produce no result keep draining.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gray_minpool_binarize_macros.svh"

module gray_minpool_binarize (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gmb_pkg::PIX_W-1:0]         s_pixel_rgb565,
    input  logic                              s_frame_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [gmb_pkg::GRAY_W-1:0] m_pooled_value,
    output logic                              m_row_end,
    output logic                              m_frame_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  gmb_pkg::cfg_index_t               cfg_index,
    input  logic [7:0]                        cfg_data
);
    import gmb_pkg::*;

    cfg_t       cfg;
    gray_item_t item;
    logic       item_take;

    // Configuration registers
    gmb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register and luma
    gmb_luma u_luma (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_rgb565 (s_pixel_rgb565),
        .s_frame_start  (s_frame_start),
        .item           (item),
        .item_take      (item_take)
    );

    // Pooling, threshold and result register
    gmb_pool u_pool (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .item           (item),
        .item_take      (item_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pooled_value (m_pooled_value),
        .m_row_end      (m_row_end),
        .m_frame_end    (m_frame_end)
    );

    // Frame end only ever comes with row end
    `GMB_ASSERT_IMP(a_frame_end_row_end, m_valid && m_frame_end, m_row_end, "frame_end without row_end")

    // Result is either a kept minimum or the fill value
    `GMB_ASSERT_IMP(a_result_value, m_valid, (m_pooled_value > cfg.keep_threshold) || (m_pooled_value == cfg.fill_value), "pooled value neither kept nor fill")

    // An accepted transaction sits in the input register next cycle
    `GMB_ASSERT_NXT(a_accept_loads, s_valid && s_ready, item.valid, "accepted pixel not registered")

    // Input back-pressure only while a pixel is held
    `GMB_ASSERT_IMP(a_ready_when_empty, !s_ready, item.valid && !item_take, "s_ready low with free input register")

endmodule

@@ tb/gray_minpool_binarize_tb.sv @@
// ----------------------------------------------------------------------------
// gray_minpool_binarize_tb
// Self-checking testbench for the gray min-pool binarizer.
//
// Pixels go in over the s_ channel and configuration over the cfg_ channel.
// A predictor in this file tracks the window counters, the pair minimum and
// the half-row line store, and it queues the expected pooled value for each
// accepted pixel that closes a 2x2 block. Each m_ transaction is compared field
// by field with the oldest queued value. Stimulus covers pixel extremes,
// threshold edges, clamped and odd window sizes, frame wrap, frame_start
// mid-frame and resizing mid-frame. A random stream with random idle cycles
// on both channels follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gray_minpool_binarize_tb;

    import gmb_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PERCENT  = 32;
    localparam int MAX_REPORTS   = 40;
    localparam int RANDOM_PIXELS = 250;

    typedef struct packed {
        logic signed [GRAY_W-1:0] value;
        logic                     row_end;
        logic                     frame_end;
    } pooled_t;

    // DUT ports
    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [PIX_W-1:0]         s_pixel_rgb565 = '0;
    logic                     s_frame_start  = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic signed [GRAY_W-1:0] m_pooled_value;
    logic                     m_row_end;
    logic                     m_frame_end;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    cfg_index_t               cfg_index      = CFG_ROW_PIXELS;
    logic [7:0]               cfg_data       = '0;

    // Predicted configuration and pooling state
    logic [SIZE_W-1:0]        cfg_row_pixels     = ROW_PIXELS_RST;
    logic [SIZE_W-1:0]        cfg_frame_rows     = FRAME_ROWS_RST;
    logic signed [GRAY_W-1:0] cfg_keep_threshold = KEEP_THRESHOLD_RST;
    logic signed [GRAY_W-1:0] cfg_fill_value     = FILL_VALUE_RST;
    logic [COUNT_W-1:0]       col_pos            = '0;
    logic [COUNT_W-1:0]       row_pos            = '0;
    logic signed [GRAY_W-1:0] pair_min           = '0;
    logic signed [GRAY_W-1:0] line_min [LINE_DEPTH];
    logic [LINE_DEPTH-1:0]    line_written       = '0;

    pooled_t pooled_q [$];
    int      mismatches  = 0;
    int      pixels_sent = 0;
    bit      no_idle     = 1'b0;

    gray_minpool_binarize i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_rgb565 (s_pixel_rgb565),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pooled_value (m_pooled_value),
        .m_row_end      (m_row_end),
        .m_frame_end    (m_frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Clamp a size register to its legal range and force it even
    function automatic int effective_size(input logic [SIZE_W-1:0] size_reg,
                                          input int max_size);
        int size;
        size = int'(size_reg);
        if (size < 2) size = 2;
        if (size > max_size) size = max_size;
        return size & ~1;
    endfunction

    function automatic int frame_pixels();
        return effective_size(cfg_row_pixels, MAX_ROW_PIXELS) *
               effective_size(cfg_frame_rows, MAX_FRAME_ROWS);
    endfunction

    // Q0.16 luma minus 128, truncated toward zero
    function automatic logic signed [GRAY_W-1:0] signed_luma(input logic [PIX_W-1:0] px);
        int unsigned red8, green8, blue8, sum;
        int          gray;
        red8   = int'(px[15:11]) * 8;
        green8 = int'(px[10:5]) * 4;
        blue8  = int'(px[4:0]) * 8;
        sum    = red8 * W_RED + green8 * W_GREEN + blue8 * W_BLUE;
        if (sum >= OFFSET_Q16) gray = int'((sum - OFFSET_Q16) >> 16);
        else gray = -int'((OFFSET_Q16 - sum) >> 16);
        return gray[GRAY_W-1:0];
    endfunction

    // True when this pixel would read a line entry no even row has filled yet
    function automatic bit reads_unwritten_line(input logic fs);
        if (fs) return 1'b0;
        return col_pos[0] && row_pos[0] && !line_written[col_pos[SLOT_W:1]];
    endfunction

    // Advance the pooling state by one pixel and queue any pooled value
    task automatic predict_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int                       width, height, slot;
        logic signed [GRAY_W-1:0] gray, block_min;
        pooled_t                  res;
        width  = effective_size(cfg_row_pixels, MAX_ROW_PIXELS);
        height = effective_size(cfg_frame_rows, MAX_FRAME_ROWS);
        gray   = signed_luma(px);
        if (fs) begin
            col_pos = '0;
            row_pos = '0;
        end
        slot = int'(col_pos >> 1);
        if (!col_pos[0]) begin
            pair_min = gray;
        end else begin
            block_min = (gray < pair_min) ? gray : pair_min;
            if (!row_pos[0]) begin
                line_min[slot]     = block_min;
                line_written[slot] = 1'b1;
            end else begin
                if (line_min[slot] < block_min) block_min = line_min[slot];
                res.value     = (block_min > cfg_keep_threshold) ? block_min : cfg_fill_value;
                res.row_end   = (int'(col_pos) == width - 1);
                res.frame_end = res.row_end && (int'(row_pos) == height - 1);
                pooled_q.push_back(res);
            end
        end
        // Wrap at or beyond the window edge
        if (int'(col_pos) + 1 >= width) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= height) row_pos = '0;
            else row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Stall the result channel at random unless a no-idle stretch is running
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Offer one pixel and hold it until the transaction completes
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        logic start;
        start = fs || reads_unwritten_line(fs);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        s_valid        <= 1'b1;
        s_pixel_rgb565 <= px;
        s_frame_start  <= start;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(px, start);
        pixels_sent++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 16) return '1;
        return PIX_W'($urandom_range(16'hFFFF));
    endfunction

    task automatic send_pixels(input int count, input logic fs_first);
        for (int i = 0; i < count; i++) begin
            send_pixel(pick_pixel(), fs_first && (i == 0));
        end
    endtask

    // One 2x2 block starting a frame
    task automatic send_block(input logic [PIX_W-1:0] p0, p1, p2, p3);
        send_pixel(p0, 1'b1);
        send_pixel(p1, 1'b0);
        send_pixel(p2, 1'b0);
        send_pixel(p3, 1'b0);
    endtask

    // Release the pixel channel and wait for every pooled value and the pipe
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pooled_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ROW_PIXELS:     cfg_row_pixels     = data[SIZE_W-1:0];
            CFG_FRAME_ROWS:     cfg_frame_rows     = data[SIZE_W-1:0];
            CFG_KEEP_THRESHOLD: cfg_keep_threshold = data;
            CFG_FILL_VALUE:     cfg_fill_value     = data;
            default: ;
        endcase
    endtask

    // Write all four registers once the block is idle
    task automatic set_window(input logic [7:0] row_data, frame_data, thr, fill);
        drain_results();
        write_register(CFG_ROW_PIXELS, row_data);
        write_register(CFG_FRAME_ROWS, frame_data);
        write_register(CFG_KEEP_THRESHOLD, thr);
        write_register(CFG_FILL_VALUE, fill);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_REPORTS) begin
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_pooled
        pooled_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pooled_q.size() == 0) begin
                report_mismatch("pooled value with none pending", int'(m_pooled_value), 0);
            end else begin
                want = pooled_q.pop_front();
                if (m_pooled_value !== want.value)
                    report_mismatch("pooled_value", int'(m_pooled_value), int'(want.value));
                if (m_row_end !== want.row_end)
                    report_mismatch("row_end", int'(m_row_end), int'(want.row_end));
                if (m_frame_end !== want.frame_end)
                    report_mismatch("frame_end", int'(m_frame_end), int'(want.frame_end));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Two rows at the reset window, no register written
    task automatic test_reset_defaults();
        send_pixels(2 * int'(ROW_PIXELS_RST), 1'b1);
    endtask

    // Black, white and pure colors against threshold edges
    task automatic test_extreme_pixels();
        // threshold -128: a black pixel is never kept
        set_window(8'd2, 8'd2, 8'h80, 8'h7F);
        send_block(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // minimum equal to threshold fails, one above passes
        set_window(8'd2, 8'd2, 8'd122, 8'h80);
        send_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_window(8'd2, 8'd2, 8'd121, 8'h00);
        send_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_window(8'd2, 8'd2, 8'h7F, 8'h00);
        send_block(16'hF800, 16'h07E0, 16'h001F, 16'h0000);
        set_window(8'd2, 8'd2, 8'h80, 8'h00);
        send_block(16'hF800, 16'h07E0, 16'h001F, 16'hFFFF);
    endtask

    // Sizes below, above and between the legal even values
    task automatic test_size_clamp();
        logic [7:0] sizes [4][2] = '{'{8'd0, 8'd1}, '{8'd3, 8'd5},
                                     '{8'hC4, 8'd1}, '{8'd5, 8'd127}};
        for (int i = 0; i < 4; i++) begin
            set_window(sizes[i][0], sizes[i][1], 8'($urandom_range(255)),
                       8'($urandom_range(255)));
            send_pixels(frame_pixels(), 1'b1);
        end
    endtask

    // Frames back to back without frame_start, then frame_start mid-frame
    task automatic test_frame_wrap();
        set_window(8'd6, 8'd4, 8'h00, 8'h81);
        send_pixels(3 * frame_pixels(), 1'b1);
        send_pixels(10, 1'b1);
        send_pixels(frame_pixels(), 1'b1);
    endtask

    // Shrink and widen the window while counters sit inside a frame
    task automatic test_resize_midframe();
        set_window(8'd16, 8'd8, 8'hF0, 8'h10);
        send_pixels(40, 1'b1);
        // column already past the new width: wrap after the next pixel
        set_window(8'd4, 8'd8, 8'hF0, 8'h10);
        send_pixels(20, 1'b0);
        // row already past the new height
        set_window(8'd4, 8'd2, 8'hE0, 8'h20);
        send_pixels(12, 1'b0);
        set_window(8'd12, 8'd8, 8'hE0, 8'h20);
        send_pixels(40, 1'b0);
    endtask

    function automatic logic [7:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return 8'($urandom_range(1, 8) * 2);
        if (roll < 95) return 8'($urandom_range(255));
        return 8'(MAX_ROW_PIXELS);
    endfunction

    // Mostly whole frames of random pixels, some broken sequences
    task automatic test_random_stream();
        int count, n;
        count = 0;
        // long stretch with both channels always willing
        no_idle = 1'b1;
        set_window(8'd16, 8'd12, 8'($urandom_range(255)), 8'($urandom_range(255)));
        send_pixels(frame_pixels(), 1'b1);
        count += frame_pixels();
        drain_results();
        no_idle = 1'b0;
        while (count < RANDOM_PIXELS) begin
            set_window(pick_size(), pick_size(), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
            if ($urandom_range(99) < 80) begin
                n = $urandom_range(1, 3) * frame_pixels();
                if (n > 160) n = 160;
                send_pixels(n, 1'b1);
            end else begin
                n = $urandom_range(1, 40);
                for (int i = 0; i < n; i++) begin
                    send_pixel(pick_pixel(), $urandom_range(99) < 10);
                end
            end
            count += n;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence and end of run
    // ------------------------------------------------------------------------

    initial begin : run_tests
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_extreme_pixels();
        test_size_clamp();
        test_frame_wrap();
        test_resize_midframe();
        test_random_stream();
        drain_results();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Bound the run in clock cycles
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
